/* hdl/sorted_max_priority_queue_macros.svh */
`ifndef SORTED_MAX_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_MAX_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define SMPQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smpq: same-cycle check failed");

// Next-cycle implication, checked while out of reset.
`define SMPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smpq: next-cycle check failed");

`endif

/* hdl/smpq_pkg.sv */
`timescale 1ns / 1ps

package smpq_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int OCC_W = 5;

    localparam logic [1:0] ACT_INSERT  = 2'd0;
    localparam logic [1:0] ACT_EXTRACT = 2'd1;
    localparam logic [1:0] ACT_MODIFY  = 2'd2;
    localparam logic [1:0] ACT_CLEAR   = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE
    } cell_op_t;

    typedef struct packed {
        cell_op_t           op;
        logic signed [31:0] value;
        logic signed [31:0] prio;
    } cell_cmd_t;

endpackage

/* hdl/smpq_if.sv */
`timescale 1ns / 1ps

interface smpq_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic signed [31:0] item_value;
    logic signed [31:0] item_priority;

    modport source (output valid, action, item_value, item_priority, input ready);
    modport sink (input valid, action, item_value, item_priority, output ready);
endinterface

interface smpq_rsp_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] taken_value;
    logic signed [31:0] top_value;
    logic               top_valid;
    logic [4:0]         occupancy;

    modport source (output valid, status, taken_value, top_value, top_valid, occupancy,
                    input ready);
    modport sink (input valid, status, taken_value, top_value, top_valid, occupancy,
                  output ready);
endinterface

/* hdl/sorted_max_priority_queue.sv */
`timescale 1ns / 1ps
// Sorted max-priority queue of up to DEPTH (value, priority) entries.
// req channel: action, item_value, item_priority; rsp channel: status,
// taken_value, top_value, top_valid, occupancy. One rsp item per req item.
// Entries sit in a row of cells in descending priority order, cell 0 on top;
// equal priorities keep arrival order. Every cell compares against the
// broadcast item at once and shifts toward its neighbor in the same cycle.
// Insert, extract and clear are handled on acceptance; the result is registered and
// shows on rsp the cycle after acceptance. A found modify runs a remove pass,
// then an insert pass; otherwise modify returns ST_NOT_FOUND and changes nothing.
// Sustained rate: one item per cycle while rsp.ready is high. req.ready is low
// during the insert pass of a found modify (S_MOD_INS) and while a result is
// held in the output register with rsp.ready low; a stalled receiver holds
// the result stable and blocks the next item.
// Reset (rst_n low, asynchronous) empties the queue and drops any pending
// result; no clearing pass is needed.
module sorted_max_priority_queue
    import smpq_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    smpq_req_if.sink    req,
    smpq_rsp_if.source  rsp
);

    typedef enum logic {
        S_IDLE,
        S_MOD_INS
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               out_valid_reg, out_valid_next;
    logic [1:0]         status_reg, status_next;
    logic signed [31:0] taken_reg, taken_next;
    logic signed [31:0] top_reg, top_next;
    logic signed [31:0] pend_value_reg, pend_value_next;
    logic signed [31:0] pend_priority_reg, pend_priority_next;

    cell_cmd_t          cmd;
    logic               head_found;
    logic               load;
    logic               accept;

    logic               occ      [DEPTH];
    logic               ge       [DEPTH];
    logic               found    [DEPTH];
    logic signed [31:0] c_value  [DEPTH];
    logic signed [31:0] c_prio   [DEPTH];
    logic signed [31:0] head_next;

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            assign occ[i] = count_reg > CNT_W'(i);
            if (i == 0)
            begin : g_head
                smpq_cell u_cell (
                    .clk            (clk),
                    .cmd            (cmd),
                    .occupied       (occ[i]),
                    .left_ge        (1'b1),
                    .left_value     (cmd.value),
                    .left_priority  (cmd.prio),
                    .right_value    (c_value[i+1]),
                    .right_priority (c_prio[i+1]),
                    .found_in       (head_found),
                    .found_out      (found[i]),
                    .ge_out         (ge[i]),
                    .value          (c_value[i]),
                    .prio           (c_prio[i]),
                    .value_next     (head_next)
                );
            end
            else if (i == DEPTH - 1)
            begin : g_tail
                smpq_cell u_cell (
                    .clk            (clk),
                    .cmd            (cmd),
                    .occupied       (occ[i]),
                    .left_ge        (ge[i-1]),
                    .left_value     (c_value[i-1]),
                    .left_priority  (c_prio[i-1]),
                    .right_value    (c_value[i]),
                    .right_priority (c_prio[i]),
                    .found_in       (found[i-1]),
                    .found_out      (found[i]),
                    .ge_out         (ge[i]),
                    .value          (c_value[i]),
                    .prio           (c_prio[i]),
                    .value_next     ()
                );
            end
            else
            begin : g_mid
                smpq_cell u_cell (
                    .clk            (clk),
                    .cmd            (cmd),
                    .occupied       (occ[i]),
                    .left_ge        (ge[i-1]),
                    .left_value     (c_value[i-1]),
                    .left_priority  (c_prio[i-1]),
                    .right_value    (c_value[i+1]),
                    .right_priority (c_prio[i+1]),
                    .found_in       (found[i-1]),
                    .found_out      (found[i]),
                    .ge_out         (ge[i]),
                    .value          (c_value[i]),
                    .prio           (c_prio[i]),
                    .value_next     ()
                );
            end
        end
    endgenerate

    assign req.ready = (state_reg == S_IDLE) && (!out_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        state_next         = state_reg;
        count_next         = count_reg;
        pend_value_next    = pend_value_reg;
        pend_priority_next = pend_priority_reg;
        cmd.op             = CELL_HOLD;
        cmd.value          = req.item_value;
        cmd.prio           = req.item_priority;
        head_found         = 1'b0;
        load               = 1'b0;
        status_next        = ST_OK;
        taken_next         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    load = 1'b1;
                    unique case (req.action)
                        ACT_INSERT:
                        begin
                            if (count_reg < CNT_W'(DEPTH))
                            begin
                                cmd.op     = CELL_INSERT;
                                count_next = count_reg + 1'b1;
                            end
                            else
                            begin
                                status_next = ST_FULL;
                            end
                        end
                        ACT_EXTRACT:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                cmd.op     = CELL_REMOVE;
                                head_found = 1'b1;
                                taken_next = c_value[0];
                                count_next = count_reg - 1'b1;
                            end
                        end
                        ACT_MODIFY:
                        begin
                            if (found[DEPTH-1])
                            begin
                                cmd.op             = CELL_REMOVE;
                                count_next         = count_reg - 1'b1;
                                pend_value_next    = req.item_value;
                                pend_priority_next = req.item_priority;
                                state_next         = S_MOD_INS;
                                load               = 1'b0;
                            end
                            else
                            begin
                                status_next = ST_NOT_FOUND;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_MOD_INS:
            begin
                cmd.op     = CELL_INSERT;
                cmd.value  = pend_value_reg;
                cmd.prio   = pend_priority_reg;
                count_next = count_reg + 1'b1;
                load       = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        top_next = (count_next != '0) ? head_next : '0;

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_value_reg    <= pend_value_next;
        pend_priority_reg <= pend_priority_next;
        if (load)
        begin
            status_reg <= status_next;
            taken_reg  <= taken_next;
            top_reg    <= top_next;
        end
    end

    logic [CNT_W-1:0] occ_count_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            occ_count_reg <= count_next;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.taken_value = taken_reg;
    assign rsp.top_value   = top_reg;
    assign rsp.top_valid   = occ_count_reg != '0;
    assign rsp.occupancy   = OCC_W'(occ_count_reg);

endmodule

/* hdl/smpq_cell.sv */
`timescale 1ns / 1ps

module smpq_cell
    import smpq_pkg::*;
(
    input  logic               clk,
    input  cell_cmd_t          cmd,
    input  logic               occupied,
    input  logic               left_ge,
    input  logic signed [31:0] left_value,
    input  logic signed [31:0] left_priority,
    input  logic signed [31:0] right_value,
    input  logic signed [31:0] right_priority,
    input  logic               found_in,
    output logic               found_out,
    output logic               ge_out,
    output logic signed [31:0] value,
    output logic signed [31:0] prio,
    output logic signed [31:0] value_next
);

    logic signed [31:0] value_reg;
    logic signed [31:0] priority_reg;
    logic signed [31:0] priority_next;

    assign ge_out    = occupied && (priority_reg >= cmd.prio);
    assign found_out = found_in || (occupied && (value_reg == cmd.value));
    assign value     = value_reg;
    assign prio      = priority_reg;

    always_comb
    begin
        value_next    = value_reg;
        priority_next = priority_reg;
        case (cmd.op)
            CELL_INSERT:
            begin
                if (!ge_out)
                begin
                    if (left_ge)
                    begin
                        value_next    = cmd.value;
                        priority_next = cmd.prio;
                    end
                    else
                    begin
                        value_next    = left_value;
                        priority_next = left_priority;
                    end
                end
            end
            CELL_REMOVE:
            begin
                if (found_out)
                begin
                    value_next    = right_value;
                    priority_next = right_priority;
                end
            end
            default:
            begin
                value_next    = value_reg;
                priority_next = priority_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg    <= value_next;
        priority_reg <= priority_next;
    end

endmodule

/* hdl/smpq_checker.sv */
`timescale 1ns / 1ps
`include "sorted_max_priority_queue_macros.svh"

module smpq_port_checker
    import smpq_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input logic [1:0]         status,
    input logic signed [31:0] taken_value,
    input logic signed [31:0] top_value,
    input logic               top_valid,
    input logic [4:0]         occupancy
);

    logic full_seen;
    logic empty_seen;
    logic empty_top;
    logic stalled;

    assign full_seen  = rsp_valid && (status == ST_FULL);
    assign empty_seen = rsp_valid && (status == ST_EMPTY);
    assign empty_top  = rsp_valid && !top_valid;
    assign stalled    = rsp_valid && !rsp_ready;

    `SMPQ_ASSERT_IMPLY(a_top_matches_count, clk, rst_n, rsp_valid, top_valid == (occupancy != '0))
    `SMPQ_ASSERT_IMPLY(a_empty_top_zero, clk, rst_n, empty_top, top_value == '0)
    `SMPQ_ASSERT_IMPLY(a_full_at_depth, clk, rst_n, full_seen, occupancy == OCC_W'(DEPTH))
    `SMPQ_ASSERT_IMPLY(a_empty_nothing_taken, clk, rst_n, empty_seen, taken_value == '0)
    `SMPQ_ASSERT_NEXT(a_stall_holds, clk, rst_n, stalled, rsp_valid && $stable(top_value))

endmodule

bind sorted_max_priority_queue smpq_port_checker u_smpq_port_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .status      (rsp.status),
    .taken_value (rsp.taken_value),
    .top_value   (rsp.top_value),
    .top_valid   (rsp.top_valid),
    .occupancy   (rsp.occupancy)
);
